// ===== hdl/local_alignment_score_array_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the local alignment score array
// Clocked, reset-gated property checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LOCAL_ALIGNMENT_SCORE_ARRAY_TOP_ASSERT_SVH
`define LOCAL_ALIGNMENT_SCORE_ARRAY_TOP_ASSERT_SVH

// Property checked on every rising clk edge outside reset.
`define LASA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression that must never be true.
`define LASA_ASSERT_NEVER(lbl, expr, msg) \
	`LASA_ASSERT(lbl, !(expr), msg)

`endif

// ===== hdl/lasa_pkg.sv =====
// ----------------------------------------------------------------------------
// lasa_pkg
// Shared types and constants of the local alignment score array.
// ----------------------------------------------------------------------------
`default_nettype none

package lasa_pkg;

	localparam int QUERY_CELLS  = 32;
	localparam int COLUMN_BITS  = 16;
	localparam int PACKED_BASES = 32;
	localparam int SCORE_BITS   = 9;
	localparam int ROW_BITS     = 6;
	localparam int QUERY_BITS   = 2 * PACKED_BASES;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
	localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;

	typedef logic [1:0]             base_t;
	typedef logic [SCORE_BITS-1:0]  score_t;
	typedef logic [ROW_BITS-1:0]    row_t;
	typedef logic [COLUMN_BITS-1:0] column_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_QUERY_BASES = 3'd0,
		REG_QUERY_LEN   = 3'd1,
		REG_MATCH       = 3'd2,
		REG_MISMATCH    = 3'd3,
		REG_GAP         = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	typedef struct packed {
		logic [3:0] match_bonus;
		logic [3:0] mismatch_penalty;
		logic [3:0] gap_penalty;
	} scores_t;

	// Wavefront token handed from one cell to the next
	typedef struct packed {
		logic    valid;
		base_t   base;
		score_t  up;
		score_t  diag;
		score_t  best_score;
		row_t    best_row;
		column_t best_column;
		column_t column;
	} link_t;

endpackage

`default_nettype wire

// ===== hdl/lasa_cell.sv =====
// ----------------------------------------------------------------------------
// lasa_cell
// One query row: holds its score of the previous column, scores the new
// cell when the token passes and carries the running best along.
// ----------------------------------------------------------------------------
`default_nettype none

module lasa_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  lasa_pkg::row_t    row,
	input  lasa_pkg::base_t   qbase,
	input  logic              active,
	input  lasa_pkg::scores_t scores,
	input  lasa_pkg::link_t   link_in,
	output lasa_pkg::link_t   link_out
);
	import lasa_pkg::*;

	score_t prev_q;
	link_t  link_q;
	link_t  link_next;

	logic signed [SCORE_BITS+1:0] diag_s;
	logic signed [SCORE_BITS+1:0] up_s;
	logic signed [SCORE_BITS+1:0] left_s;
	logic signed [SCORE_BITS+1:0] d_s;
	logic signed [SCORE_BITS+1:0] m_s;
	score_t score_new;
	logic   better;

	always_comb begin
		diag_s = signed'({2'b00, link_in.diag});
		up_s   = signed'({2'b00, link_in.up});
		left_s = signed'({2'b00, prev_q});
		if (qbase == link_in.base) begin
			d_s = diag_s + signed'({{(SCORE_BITS-2){1'b0}}, scores.match_bonus});
		end else begin
			d_s = diag_s - signed'({{(SCORE_BITS-2){1'b0}}, scores.mismatch_penalty});
		end
		m_s = '0;
		if (d_s > m_s) m_s = d_s;
		if (up_s - signed'({{(SCORE_BITS-2){1'b0}}, scores.gap_penalty}) > m_s)
			m_s = up_s - signed'({{(SCORE_BITS-2){1'b0}}, scores.gap_penalty});
		if (left_s - signed'({{(SCORE_BITS-2){1'b0}}, scores.gap_penalty}) > m_s)
			m_s = left_s - signed'({{(SCORE_BITS-2){1'b0}}, scores.gap_penalty});
		// saturate
		if (m_s > signed'({2'b00, SCORE_MAX})) begin
			score_new = SCORE_MAX;
		end else begin
			score_new = m_s[SCORE_BITS-1:0];
		end

		better = active && (score_new != '0) &&
			((score_new > link_in.best_score) ||
			 ((score_new == link_in.best_score) && (row < link_in.best_row)));

		link_next = link_in;
		if (active) begin
			link_next.up   = score_new;
			link_next.diag = prev_q;
		end
		if (better) begin
			link_next.best_score  = score_new;
			link_next.best_row    = row;
			link_next.best_column = link_in.column;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (clear) begin
			prev_q <= '0;
		end else if (link_in.valid && active) begin
			prev_q <= score_new;
		end
	end

	// payload follows the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_next;
		end
	end

	assign link_out = link_q;

endmodule

`default_nettype wire

// ===== hdl/local_alignment_score_array_top.sv =====
// ----------------------------------------------------------------------------
// local_alignment_score_array_top
// Local alignment scoring with a linear gap on a row of query cells.
//
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tdata[1:0] subject_base, tlast last_base
// m_*      out  tvalid/tready    tdata best_score/best_row/best_column,
//                                tlast alignment_done
// cfg_*    in   cfg_wr_en        cfg_index register, cfg_data value
//
// Each subject base enters cell 0 and moves down the row one cell per cycle.
// One item is in the row at a time; the next is taken once the result has
// left the last cell and the spare slot is not full.
// A result register plus one spare slot hold results while m_tready is low;
// s_tready also drops while the spare slot is full.
// Reset clears configuration to defaults and all alignment state at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "local_alignment_score_array_top_assert.svh"

module local_alignment_score_array_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// subject bases
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] subject_base, [7:2] zero
	input  logic        s_tlast,   // last_base
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [8:0] best_score, [14:9] best_row,
	                               // [30:15] best_column, [31] zero
	output logic        m_tlast    // alignment_done
);
	import lasa_pkg::*;

	// configuration
	logic [QUERY_BITS-1:0] query_q;
	logic [5:0]            len_q;
	scores_t               scores_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q                   <= '0;
			len_q                     <= 6'd32;
			scores_q.match_bonus      <= 4'd3;
			scores_q.mismatch_penalty <= 4'd3;
			scores_q.gap_penalty      <= 4'd2;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_QUERY_BASES: query_q <= cfg_data[QUERY_BITS-1:0];
				REG_QUERY_LEN:   len_q <= cfg_data[5:0];
				REG_MATCH:       scores_q.match_bonus <= cfg_data[3:0];
				REG_MISMATCH:    scores_q.mismatch_penalty <= cfg_data[3:0];
				REG_GAP:         scores_q.gap_penalty <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// control
	state_t  state_q;
	state_t  state_next;
	logic    inject;
	logic    end_valid;
	logic    clear_cells;
	logic    last_q;
	logic    pend_q;
	logic    m_tvalid_q;

	score_t  best_score_q;
	row_t    best_row_q;
	column_t col_q;
	column_t col_next;
	column_t best_col_q;

	link_t   links [QUERY_CELLS+1];
	logic [QUERY_CELLS-1:0] token_vec;

	assign end_valid = links[QUERY_CELLS].valid;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) state_next = ST_BUSY;
			ST_BUSY: if (end_valid) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = (state_q == ST_IDLE) && !pend_q;
		inject      = s_tvalid && s_tready;
		clear_cells = end_valid && last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign col_next = (col_q == COLUMN_MAX) ? col_q : col_q + 1'b1;

	// alignment state kept between columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			best_score_q <= '0;
			best_row_q   <= '0;
			best_col_q   <= '0;
			last_q       <= 1'b0;
		end else if (inject) begin
			col_q  <= col_next;
			last_q <= s_tlast;
		end else if (end_valid) begin
			if (last_q) begin
				col_q        <= '0;
				best_score_q <= '0;
				best_row_q   <= '0;
				best_col_q   <= '0;
			end else begin
				best_score_q <= links[QUERY_CELLS].best_score;
				best_row_q   <= links[QUERY_CELLS].best_row;
				best_col_q   <= links[QUERY_CELLS].best_column;
			end
		end
	end

	// row of cells
	assign links[0] = '{
		valid:       inject,
		base:        s_tdata[1:0],
		up:          '0,
		diag:        '0,
		best_score:  best_score_q,
		best_row:    best_row_q,
		best_column: best_col_q,
		column:      col_next
	};

	for (genvar i = 0; i < QUERY_CELLS; i++) begin : g_cell
		base_t qbase;
		logic  active;

		if (i < PACKED_BASES) begin : g_packed
			assign qbase  = query_q[QUERY_BITS-1-2*i -: 2];
			assign active = int'(len_q) > i;
		end else begin : g_spare
			assign qbase  = '0;
			assign active = 1'b0;
		end

		assign token_vec[i] = links[i+1].valid;

		lasa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (clear_cells),
			.row      (ROW_BITS'(i + 1)),
			.qbase    (qbase),
			.active   (active),
			.scores   (scores_q),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	// result register and spare slot
	logic [31:0] end_word;
	logic [31:0] out_q;
	logic [31:0] pend_data_q;
	logic        out_last_q;
	logic        pend_last_q;
	logic        load_out;

	assign end_word = {1'b0, links[QUERY_CELLS].best_column,
	                   links[QUERY_CELLS].best_row, links[QUERY_CELLS].best_score};
	assign load_out = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			pend_q     <= 1'b0;
		end else if (end_valid) begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else begin
				pend_q <= 1'b1;
			end
		end else if (m_tvalid_q && m_tready) begin
			if (pend_q) begin
				pend_q <= 1'b0;
			end else begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (end_valid) begin
			if (load_out) begin
				out_q      <= end_word;
				out_last_q <= last_q;
			end else begin
				pend_data_q <= end_word;
				pend_last_q <= last_q;
			end
		end else if (m_tvalid_q && m_tready && pend_q) begin
			out_q      <= pend_data_q;
			out_last_q <= pend_last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign m_tlast  = out_last_q;

	`LASA_ASSERT(a_spare_needs_out, pend_q |-> m_tvalid_q, "spare slot full with empty output")
	`LASA_ASSERT(a_accept_busy, (s_tvalid && s_tready) |=> (state_q == ST_BUSY), "accept did not start row")
	`LASA_ASSERT(a_one_token, $onehot0(token_vec), "more than one token in the row")
	`LASA_ASSERT_NEVER(a_end_when_idle, end_valid && (state_q == ST_IDLE), "result without item")

endmodule

`default_nettype wire
